// ===== rtl/core/procedural_icon_pixel_assert.svh =====
// Assertion macros shared by the RTL of the icon pixel block.
// Every macro samples on clk and is switched off while arst_n is low.
`ifndef PROCEDURAL_ICON_PIXEL_ASSERT_SVH
`define PROCEDURAL_ICON_PIXEL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pip_pkg.sv =====
package pip_pkg;

	// Fraction bits of the distance from the icon center.
	localparam int DIST_FRAC_BITS = 4;
	localparam int HALF_SHIFT     = DIST_FRAC_BITS - 1;

	localparam int AW        = 8;                  // |2p - 255|
	localparam int QW        = 2 * AW + 1;         // ax^2 + ay^2
	localparam int RW        = DIST_FRAC_BITS + 8; // distance and root width
	localparam int SW        = 2 * RW;             // radicand, padded to even width
	localparam int SQ_STAGES = (RW + 1) / 2;       // two root bits per stage
	localparam int UW        = DIST_FRAC_BITS + 5; // offset into the outline band
	localparam int BW        = DIST_FRAC_BITS + 12;// color blend sum
	localparam int NW        = 19;                 // soft ramp numerator
	localparam int NPW       = RW + 12;
	localparam int VW        = 16;                 // alpha before scaling, Q.8
	localparam int SFW       = 17;                 // soft ramp before saturation
	localparam int SCW       = 17;                 // alpha scale, Q1.16
	localparam int AFW       = 34;
	localparam int PADDR_W   = 3;

	// Division by seven through a reciprocal; exact for numerators below 2^22 / 5.
	localparam int RECIP_SHIFT = 22;
	localparam int RECIP_W     = 20;
	localparam logic [RECIP_W-1:0] RECIP_SEVEN = RECIP_W'(((1 << RECIP_SHIFT) + 6) / 7);

	localparam logic [RW-1:0] T92  = RW'(92 << DIST_FRAC_BITS);
	localparam logic [RW-1:0] T108 = RW'(108 << DIST_FRAC_BITS);
	localparam logic [RW-1:0] T128 = RW'(128 << DIST_FRAC_BITS);
	localparam logic [UW-1:0] BAND_DEN  = UW'(16 << DIST_FRAC_BITS);
	localparam logic [BW-1:0] BAND_HALF = BW'(8 << DIST_FRAC_BITS);

	localparam logic [11:0]    OUTL_MUL   = 12'd4080;
	localparam logic [VW-1:0]  VMAX       = 16'hFF00;
	localparam logic [AFW-1:0] ALPHA_HALF = AFW'(1 << 23);
	localparam logic [8:0]     ABS_MID    = 9'd255;

	localparam logic [17:0] LUM_R     = 18'd299;
	localparam logic [17:0] LUM_G     = 18'd587;
	localparam logic [17:0] LUM_B     = 18'd114;
	localparam logic [17:0] LUM_SPLIT = 18'd127500;

	localparam logic [7:0] STYLE_LO      = 8'h10;
	localparam logic [7:0] STYLE_END     = 8'hD0;
	localparam logic [7:0] STYLE_DEFAULT = 8'h4F;

	localparam logic [1:0] SHAPE_CIRCLE  = 2'd0;
	localparam logic [1:0] SHAPE_SQUARE  = 2'd1;
	localparam logic [1:0] SHAPE_DIAMOND = 2'd2;

	localparam logic [1:0] MODE_SOFT    = 2'd0;
	localparam logic [1:0] MODE_OUTLINE = 2'd1;
	localparam logic [1:0] MODE_HARD    = 2'd2;
	localparam logic [1:0] MODE_FILLED  = 2'd3;

	localparam logic REG_ICON_RGB   = 1'b0;
	localparam logic REG_ICON_STYLE = 1'b1;

	typedef logic [7:0] coord_t;
	typedef logic [7:0] chan_t;

	// round(65536 * 2^((k - 15) / 3))
	function automatic logic [SCW-1:0] alpha_scale(input logic [3:0] k);
		logic [SCW-1:0] s;
		case (k)
			4'd0: s = 17'd2048;
			4'd1: s = 17'd2580;
			4'd2: s = 17'd3251;
			4'd3: s = 17'd4096;
			4'd4: s = 17'd5161;
			4'd5: s = 17'd6502;
			4'd6: s = 17'd8192;
			4'd7: s = 17'd10321;
			4'd8: s = 17'd13004;
			4'd9: s = 17'd16384;
			4'd10: s = 17'd20643;
			4'd11: s = 17'd26008;
			4'd12: s = 17'd32768;
			4'd13: s = 17'd41285;
			4'd14: s = 17'd52016;
			4'd15: s = 17'd65536;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/core/pip_stream_if.sv =====
interface pip_coord_if;
	logic              valid;
	logic              ready;
	pip_pkg::coord_t   pixel_x;
	pip_pkg::coord_t   pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface pip_pixel_if;
	logic            valid;
	logic            ready;
	pip_pkg::chan_t  red;
	pip_pkg::chan_t  green;
	pip_pkg::chan_t  blue;
	pip_pkg::chan_t  alpha;

	modport source (output valid, output red, output green, output blue, output alpha,
		input ready);
	modport sink (input valid, input red, input green, input blue, input alpha,
		output ready);
endinterface

// ===== rtl/core/procedural_icon_pixel.sv =====
// Channel   Kind            Beat contents
// coord     valid/ready in  pixel_x, pixel_y (8 bits each)
// pixel     valid/ready out red, green, blue, alpha (8 bits each)
// APB       psel/penable    icon_rgb at 0x0, icon_style at 0x4, pready tied high
//
// One beat enters per clock and one leaves per clock when the sink keeps up.
// A beat accepted on coord passes thirteen register stages on its way to
// pixel, six of them for the integer square root of the circle shape at
// two root bits per stage.
// Reset clears both registers and all stage valid bits, not the data path.
// Each stage moves on when it is empty or when the stage after it moves, so a
// stall on pixel fills bubbles first and then holds every beat in place.
`include "procedural_icon_pixel_assert.svh"

module procedural_icon_pixel (
	input  logic                        clk,
	input  logic                        arst_n,
	pip_coord_if.sink                   coord,
	pip_pixel_if.source                 pixel,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pip_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int RW   = pip_pkg::RW;
	localparam int SW   = pip_pkg::SW;
	localparam int UW   = pip_pkg::UW;
	localparam int BW   = pip_pkg::BW;
	localparam int NW   = pip_pkg::NW;
	localparam int VW   = pip_pkg::VW;
	localparam int FB   = pip_pkg::DIST_FRAC_BITS;
	localparam int NSQ  = pip_pkg::SQ_STAGES;

	// Stage positions in the valid vector.
	localparam int IX_S1 = 0;
	localparam int IX_S2 = 1;
	localparam int IX_SQ = 2;
	localparam int IX_S4 = IX_SQ + NSQ;
	localparam int IX_S5 = IX_S4 + 1;
	localparam int IX_S6 = IX_S4 + 2;
	localparam int IX_S7 = IX_S4 + 3;
	localparam int IX_S8 = IX_S4 + 4;
	localparam int NST   = IX_S8 + 1;

	// ------------------------------------------------------------------
	// Configuration registers. The user must change them only while the pipeline
	// is empty; the block does not enforce it. Stages read them without copies.
	// ------------------------------------------------------------------
	logic [23:0] icon_rgb_q;
	logic [7:0]  icon_style_q;
	logic        outl_white_q;
	logic        wr_en;
	logic [7:0]  sty_fix;
	logic [1:0]  shape;
	logic [1:0]  mode;
	logic [3:0]  kidx;
	logic [17:0] lum;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icon_rgb_q   <= '0;
			icon_style_q <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				pip_pkg::REG_ICON_RGB: icon_rgb_q <= pwdata[23:0];
				pip_pkg::REG_ICON_STYLE: icon_style_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			pip_pkg::REG_ICON_RGB: prdata = {8'h00, icon_rgb_q};
			pip_pkg::REG_ICON_STYLE: prdata = {24'h000000, icon_style_q};
			default: prdata = '0;
		endcase
	end

	// Styles outside the legal window fall back to the default style byte.
	always_comb begin
		if (icon_style_q inside {[pip_pkg::STYLE_LO : pip_pkg::STYLE_END - 8'd1]}) begin
			sty_fix = icon_style_q - pip_pkg::STYLE_LO;
		end else begin
			sty_fix = pip_pkg::STYLE_DEFAULT - pip_pkg::STYLE_LO;
		end
	end

	assign shape = sty_fix[7:6];
	assign mode  = sty_fix[5:4];
	assign kidx  = sty_fix[3:0];

	// Dark base colors get a white outline in filled mode, light ones a black one.
	assign lum = pip_pkg::LUM_R * 18'(icon_rgb_q[23:16])
		+ pip_pkg::LUM_G * 18'(icon_rgb_q[15:8])
		+ pip_pkg::LUM_B * 18'(icon_rgb_q[7:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outl_white_q <= 1'b1;
		end else begin
			outl_white_q <= (lum < pip_pkg::LUM_SPLIT);
		end
	end

	// ------------------------------------------------------------------
	// Flow control. A stage advances when it is empty or its successor
	// advances; the valid bits shift along with the data.
	// ------------------------------------------------------------------
	logic [NST-1:0] vld_q;
	logic [NST-1:0] vld_in;
	logic [NST-1:0] adv;

	assign vld_in = {vld_q[NST-2:0], coord.valid};

	always_comb begin
		adv[NST-1] = !vld_q[NST-1] || pixel.ready;
		for (int i = NST - 2; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NST; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_in[i];
				end
			end
		end
	end

	assign coord.ready = adv[IX_S1];

	// ------------------------------------------------------------------
	// Stage 1: offsets from the center in half-pixel units, |2p - 255|.
	// ------------------------------------------------------------------
	logic [8:0]             x2;
	logic [8:0]             y2;
	logic [pip_pkg::AW-1:0] ax_nx;
	logic [pip_pkg::AW-1:0] ay_nx;
	logic [pip_pkg::AW-1:0] ax_s1;
	logic [pip_pkg::AW-1:0] ay_s1;

	assign x2    = {coord.pixel_x, 1'b0};
	assign y2    = {coord.pixel_y, 1'b0};
	assign ax_nx = (x2 >= pip_pkg::ABS_MID) ? 8'(x2 - pip_pkg::ABS_MID)
		: 8'(pip_pkg::ABS_MID - x2);
	assign ay_nx = (y2 >= pip_pkg::ABS_MID) ? 8'(y2 - pip_pkg::ABS_MID)
		: 8'(pip_pkg::ABS_MID - y2);

	always_ff @(posedge clk) begin
		if (adv[IX_S1]) begin
			ax_s1 <= ax_nx;
			ay_s1 <= ay_nx;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: squared radius for the circle, and the square or diamond
	// distance, both scaled to DIST_FRAC_BITS fraction bits.
	// ------------------------------------------------------------------
	logic [pip_pkg::QW-1:0] qsum;
	logic [8:0]             lin9;
	logic [SW-1:0]          sq_s2;
	logic [RW-1:0]          lin_s2;

	assign qsum = pip_pkg::QW'(ax_s1) * pip_pkg::QW'(ax_s1)
		+ pip_pkg::QW'(ay_s1) * pip_pkg::QW'(ay_s1);

	always_comb begin
		case (shape)
			pip_pkg::SHAPE_SQUARE: lin9 = {1'b0, (ax_s1 > ay_s1) ? ax_s1 : ay_s1};
			default: lin9 = 9'(ax_s1) + 9'(ay_s1);
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[IX_S2]) begin
			sq_s2  <= SW'(qsum) << (2 * pip_pkg::HALF_SHIFT);
			lin_s2 <= RW'(lin9) << pip_pkg::HALF_SHIFT;
		end
	end

	// ------------------------------------------------------------------
	// Square root stages, restoring method, two root bits per stage. The
	// radicand shifts left as its bit pairs are consumed; the remainder
	// leaves the last stage as s - root^2.
	// ------------------------------------------------------------------
	logic [RW-1:0] sqr_root_s3 [NSQ];
	logic [RW+1:0] sqr_rem_s3  [NSQ];
	logic [SW-1:0] sqr_rad_s3  [NSQ];
	logic [RW-1:0] sqr_lin_s3  [NSQ];

	genvar gj;
	generate
		for (gj = 0; gj < NSQ; gj++) begin : g_sqrt
			logic [RW-1:0] root_in;
			logic [RW+1:0] rem_in;
			logic [SW-1:0] rad_in;
			logic [RW-1:0] lin_in;
			logic [RW-1:0] root_nx;
			logic [RW+1:0] rem_nx;
			logic [SW-1:0] rad_nx;

			if (gj == 0) begin : g_first
				assign root_in = '0;
				assign rem_in  = '0;
				assign rad_in  = sq_s2;
				assign lin_in  = lin_s2;
			end else begin : g_rest
				assign root_in = sqr_root_s3[gj-1];
				assign rem_in  = sqr_rem_s3[gj-1];
				assign rad_in  = sqr_rad_s3[gj-1];
				assign lin_in  = sqr_lin_s3[gj-1];
			end

			always_comb begin : p_step
				logic [RW+3:0] acc;
				logic [RW+3:0] trial;
				root_nx = root_in;
				rem_nx  = rem_in;
				rad_nx  = rad_in;
				acc     = '0;
				trial   = '0;
				for (int b = 0; b < 2; b++) begin
					if (2 * gj + b < RW) begin
						acc    = {rem_nx, rad_nx[SW-1 -: 2]};
						trial  = (RW+4)'({root_nx, 2'b01});
						rad_nx = rad_nx << 2;
						if (acc >= trial) begin
							rem_nx  = (RW+2)'(acc - trial);
							root_nx = {root_nx[RW-2:0], 1'b1};
						end else begin
							rem_nx  = acc[RW+1:0];
							root_nx = {root_nx[RW-2:0], 1'b0};
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (adv[IX_SQ+gj]) begin
					sqr_root_s3[gj] <= root_nx;
					sqr_rem_s3[gj]  <= rem_nx;
					sqr_rad_s3[gj]  <= rad_nx;
					sqr_lin_s3[gj]  <= lin_in;
				end
			end
		end
	endgenerate

	// ------------------------------------------------------------------
	// Stage 4: the circle rounds its root half up (remainder above the
	// root); the other shapes take the linear distance.
	// ------------------------------------------------------------------
	logic          round_up;
	logic [RW-1:0] dist_s4;

	assign round_up = sqr_rem_s3[NSQ-1] > (RW+2)'(sqr_root_s3[NSQ-1]);

	always_ff @(posedge clk) begin
		if (adv[IX_S4]) begin
			if (shape == pip_pkg::SHAPE_CIRCLE) begin
				dist_s4 <= sqr_root_s3[NSQ-1] + RW'(round_up);
			end else begin
				dist_s4 <= sqr_lin_s3[NSQ-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: threshold compares, the soft ramp numerator
	// (128 - d) * 4080 / 2^F and the offset into the outline band.
	// ------------------------------------------------------------------
	localparam int NPW_W = pip_pkg::NPW;
	logic [NPW_W-1:0] nfull;
	logic          lt128;
	logic          lt92_s5;
	logic          lt108_s5;
	logic          gt92_s5;
	logic          gt108_s5;
	logic          gt128_s5;
	logic [NW-1:0] soft_n_s5;
	logic [UW-1:0] u_s5;

	assign lt128 = dist_s4 < pip_pkg::T128;
	assign nfull = NPW_W'(pip_pkg::T128 - dist_s4) * NPW_W'(pip_pkg::OUTL_MUL);

	always_ff @(posedge clk) begin
		if (adv[IX_S5]) begin
			lt92_s5   <= dist_s4 < pip_pkg::T92;
			lt108_s5  <= dist_s4 < pip_pkg::T108;
			gt92_s5   <= dist_s4 > pip_pkg::T92;
			gt108_s5  <= dist_s4 > pip_pkg::T108;
			gt128_s5  <= dist_s4 > pip_pkg::T128;
			soft_n_s5 <= lt128 ? nfull[FB +: NW] : '0;
			u_s5      <= UW'(dist_s4 - pip_pkg::T92);
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: soft ramp divided by seven, outline ramp, and the filled
	// mode color blend toward the outline color inside the band.
	// ------------------------------------------------------------------
	localparam int SPW = NW + pip_pkg::RECIP_W;
	localparam int OPW = UW + 12;

	logic [SPW-1:0]         sprod;
	logic [OPW-1:0]         oprod;
	logic [7:0]             ocol;
	logic [7:0]             col_nx [3];
	logic [pip_pkg::SFW-1:0] soft_s6;
	logic [VW-1:0]          oln_s6;
	logic                   lt92_s6;
	logic                   lt108_s6;
	logic                   gt128_s6;
	logic [7:0]             col_s6 [3];

	assign sprod = SPW'(soft_n_s5) * SPW'(pip_pkg::RECIP_SEVEN);
	assign oprod = OPW'(u_s5) * OPW'(pip_pkg::OUTL_MUL);
	assign ocol  = {8{outl_white_q}};

	always_comb begin : p_blend
		logic [7:0]    base;
		logic [BW-1:0] mix;
		base = '0;
		mix  = '0;
		for (int c = 0; c < 3; c++) begin
			base = icon_rgb_q[8*(2-c) +: 8];
			mix  = BW'(base) * BW'(pip_pkg::BAND_DEN - u_s5)
				+ (outl_white_q ? BW'(u_s5) * BW'(8'd255) : '0)
				+ pip_pkg::BAND_HALF;
			if (mode == pip_pkg::MODE_FILLED && gt108_s5) begin
				col_nx[c] = ocol;
			end else if (mode == pip_pkg::MODE_FILLED && gt92_s5) begin
				col_nx[c] = mix[FB+4 +: 8];
			end else begin
				col_nx[c] = base;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[IX_S6]) begin
			soft_s6  <= sprod[pip_pkg::RECIP_SHIFT +: pip_pkg::SFW];
			oln_s6   <= oprod[FB +: VW];
			lt92_s6  <= lt92_s5;
			lt108_s6 <= lt108_s5;
			gt128_s6 <= gt128_s5;
			col_s6   <= col_nx;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: alpha before scaling, chosen by the edge mode.
	// ------------------------------------------------------------------
	logic [VW-1:0] v_nx;
	logic [VW-1:0] v_s7;
	logic [7:0]    col_s7 [3];

	always_comb begin
		case (mode)
			pip_pkg::MODE_SOFT: begin
				v_nx = (soft_s6 > pip_pkg::SFW'(pip_pkg::VMAX)) ? pip_pkg::VMAX
					: soft_s6[VW-1:0];
			end
			pip_pkg::MODE_OUTLINE: begin
				if (lt92_s6 || gt128_s6) begin
					v_nx = '0;
				end else if (lt108_s6) begin
					v_nx = oln_s6;
				end else begin
					v_nx = pip_pkg::VMAX;
				end
			end
			default: v_nx = gt128_s6 ? '0 : pip_pkg::VMAX;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[IX_S7]) begin
			v_s7   <= v_nx;
			col_s7 <= col_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 8, the output register: alpha scale with rounding.
	// ------------------------------------------------------------------
	logic [pip_pkg::AFW-1:0] aprod;
	logic [7:0]              alpha_s8;
	logic [7:0]              col_s8 [3];

	assign aprod = pip_pkg::AFW'(v_s7) * pip_pkg::AFW'(pip_pkg::alpha_scale(kidx))
		+ pip_pkg::ALPHA_HALF;

	always_ff @(posedge clk) begin
		if (adv[IX_S8]) begin
			alpha_s8 <= aprod[24 +: 8];
			col_s8   <= col_s7;
		end
	end

	assign pixel.valid = vld_q[IX_S8];
	assign pixel.red   = col_s8[0];
	assign pixel.green = col_s8[1];
	assign pixel.blue  = col_s8[2];
	assign pixel.alpha = alpha_s8;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`PIP_ASSERT_NOW(a_root_remainder, vld_q[IX_S4-1],
		sqr_rem_s3[NSQ-1] <= (RW+2)'({sqr_root_s3[NSQ-1], 1'b0}),
		"square root remainder exceeds twice the root")
	`PIP_ASSERT_NOW(a_alpha_bound, vld_q[IX_S7], v_s7 <= pip_pkg::VMAX,
		"unscaled alpha above full scale")
	`PIP_ASSERT_NEXT(a_zero_alpha, vld_q[IX_S7] && adv[IX_S8] && (v_s7 == '0),
		alpha_s8 == '0, "zero coverage produced nonzero alpha")
	`PIP_ASSERT_NEXT(a_filled_outline,
		vld_q[IX_S5] && adv[IX_S6] && (mode == pip_pkg::MODE_FILLED) && gt108_s5,
		(col_s6[0] == ocol) && (col_s6[1] == ocol) && (col_s6[2] == ocol),
		"filled mode outside the band did not take the outline color")

endmodule
